/* design/ttsi_pkg.sv */
`default_nettype none
package ttsi_pkg;

	// Offset counter width and output widths
	localparam int OFFSET_BITS = 16;
	localparam int END_OFS_W   = 16;
	localparam int BASE_W      = 6;
	localparam int VALUE_W     = 64;
	localparam int CHAR_W      = 8;
	localparam int PROD_W      = VALUE_W + BASE_W + 1;

	// Queue depths
	localparam int MID_DEPTH  = 4;
	localparam int MID_PTR_W  = $clog2(MID_DEPTH);
	localparam int MID_CNT_W  = $clog2(MID_DEPTH + 1);
	localparam int RES_DEPTH  = 2;
	localparam int RES_PTR_W  = $clog2(RES_DEPTH);
	localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

	// Character codes
	localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
	localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
	localparam logic [CHAR_W-1:0] CH_PLUS     = 8'd43;
	localparam logic [CHAR_W-1:0] CH_MINUS    = 8'd45;
	localparam logic [CHAR_W-1:0] CH_ZERO     = 8'd48;
	localparam logic [CHAR_W-1:0] CH_NINE     = 8'd57;
	localparam logic [CHAR_W-1:0] CH_UA       = 8'd65;
	localparam logic [CHAR_W-1:0] CH_UZ       = 8'd90;
	localparam logic [CHAR_W-1:0] CH_LA       = 8'd97;
	localparam logic [CHAR_W-1:0] CH_LZ       = 8'd122;
	localparam logic [CHAR_W-1:0] CH_UX       = 8'd88;
	localparam logic [CHAR_W-1:0] CH_LX       = 8'd120;
	localparam logic [CHAR_W-1:0] CH_UPPER_OFS = CH_UA - 8'd10;
	localparam logic [CHAR_W-1:0] CH_LOWER_OFS = CH_LA - 8'd10;

	// Radix constants
	localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_W-1:0] BASE_MIN  = 6'd2;
	localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
	localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

	// Saturation limits
	localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_SIGN,
		PH_ZERO,
		PH_PREFIX,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_SIGN,
		ACT_ZERO,
		ACT_PREFIX,
		ACT_DIGIT,
		ACT_END_X
	} action_t;

	// Classified character word, front to back
	typedef struct packed {
		logic                   start;
		logic                   is_ws;
		logic                   is_minus;
		logic                   is_plus;
		logic                   is_zero;
		logic                   is_x;
		logic                   dig_ok;
		logic [BASE_W-1:0]      dig_val;
		logic [BASE_W-1:0]      base;
		logic [OFFSET_BITS-1:0] offset;
	} class_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      range_error;
		logic                      digits_seen;
		logic [END_OFS_W-1:0]      end_offset;
	} result_t;

endpackage
`default_nettype wire

/* design/ttsi_front.sv */
`default_nettype none
module ttsi_front import ttsi_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic              string_start,
	input  wire logic              push,
	input  wire logic              q_full,
	input  wire logic              cfg_valid,
	input  wire logic [BASE_W-1:0] cfg_data,
	output logic                   cfg_ready,
	output logic                   q_wr,
	output class_word_t            q_word
);

	logic [BASE_W-1:0]      number_base_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] cur_off;
	logic                   accept;

	assign accept    = push && !q_full;
	assign q_wr      = accept;
	assign cfg_ready = 1'b1;
	assign cur_off   = string_start ? '0 : pos_q;

	// Hold the radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= '0;
		end else if (cfg_valid) begin
			number_base_q <= cfg_data;
		end
	end

	// Advance the saturating character position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= (cur_off == POS_MAX) ? cur_off : cur_off + 1'b1;
		end
	end

	// Classify the character
	always_comb begin
		q_word          = '0;
		q_word.start    = string_start;
		q_word.base     = number_base_q;
		q_word.offset   = cur_off;
		q_word.is_ws    = (char_code == CH_SPACE) ||
			(char_code >= CH_TAB && char_code <= CH_CR);
		q_word.is_minus = (char_code == CH_MINUS);
		q_word.is_plus  = (char_code == CH_PLUS);
		q_word.is_zero  = (char_code == CH_ZERO);
		q_word.is_x     = (char_code == CH_LX) || (char_code == CH_UX);
		if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
			q_word.dig_ok  = 1'b1;
			q_word.dig_val = BASE_W'(char_code - CH_ZERO);
		end else if (char_code >= CH_UA && char_code <= CH_UZ) begin
			q_word.dig_ok  = 1'b1;
			q_word.dig_val = BASE_W'(char_code - CH_UPPER_OFS);
		end else if (char_code >= CH_LA && char_code <= CH_LZ) begin
			q_word.dig_ok  = 1'b1;
			q_word.dig_val = BASE_W'(char_code - CH_LOWER_OFS);
		end
	end

endmodule
`default_nettype wire

/* design/ttsi_word_q.sv */
`default_nettype none
module ttsi_word_q import ttsi_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr,
	input  wire class_word_t wr_word,
	output logic             full,
	input  wire logic        rd,
	output logic             empty,
	output class_word_t      rd_word
);

	class_word_t            mem_q [MID_DEPTH];
	logic [MID_PTR_W-1:0]   wr_ptr_q;
	logic [MID_PTR_W-1:0]   rd_ptr_q;
	logic [MID_CNT_W-1:0]   cnt_q;

	assign full    = (cnt_q == MID_CNT_W'(MID_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_word = mem_q[rd_ptr_q];

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/ttsi_back.sv */
`default_nettype none
module ttsi_back import ttsi_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire class_word_t word,
	input  wire logic        q_empty,
	output logic             q_pop,
	input  wire logic        res_full,
	output logic             res_push,
	output result_t          res
);

	phase_t             phase_q, phase_d, e_phase;
	logic               neg_q, neg_d, e_neg;
	logic [BASE_W-1:0]  base_q, base_d, e_base;
	logic [VALUE_W-1:0] acc_q, acc_d, e_acc;
	logic               ovf_q, ovf_d, e_ovf;
	logic               anyd_q, anyd_d, e_anyd;

	action_t            act;
	logic [BASE_W-1:0]  tb;
	logic               go;
	logic               bad;
	logic               finish;
	logic [PROD_W-1:0]  prod;
	logic [PROD_W-1:0]  lim;
	logic               ovf_hit;
	logic [OFFSET_BITS-1:0] fin_off;

	assign go    = !q_empty && !res_full;
	assign q_pop = go;

	// Effective state: a start word begins a fresh parse
	always_comb begin
		if (word.start) begin
			e_phase = PH_SPACE;
			e_neg   = 1'b0;
			e_base  = word.base;
			e_acc   = '0;
			e_ovf   = 1'b0;
			e_anyd  = 1'b0;
		end else begin
			e_phase = phase_q;
			e_neg   = neg_q;
			e_base  = base_q;
			e_acc   = acc_q;
			e_ovf   = ovf_q;
			e_anyd  = anyd_q;
		end
	end

	// Decode the action for this character
	always_comb begin
		act = ACT_NONE;
		tb  = e_base;
		unique case (e_phase)
			PH_SPACE, PH_SIGN: begin
				if (e_phase == PH_SPACE && word.is_ws) begin
					act = ACT_NONE;
				end else if (e_phase == PH_SPACE && (word.is_minus || word.is_plus)) begin
					act = ACT_SIGN;
				end else if ((e_base == BASE_AUTO || e_base == BASE_HEX) && word.is_zero) begin
					act = ACT_ZERO;
				end else begin
					act = ACT_DIGIT;
					tb  = (e_base == BASE_AUTO) ? BASE_DEC : e_base;
				end
			end
			PH_ZERO: begin
				if (word.is_x) begin
					act = ACT_PREFIX;
				end else begin
					act = ACT_DIGIT;
					tb  = (e_base == BASE_AUTO) ? BASE_OCT : e_base;
				end
			end
			PH_PREFIX: begin
				act = (word.dig_ok && word.dig_val < BASE_HEX) ? ACT_DIGIT : ACT_END_X;
			end
			PH_DIGITS: act = ACT_DIGIT;
			PH_DONE:   act = ACT_NONE;
			default:   act = ACT_NONE;
		endcase
	end

	// Multiply-accumulate and range check
	assign bad = !word.dig_ok || tb < BASE_MIN || tb > BASE_MAX || word.dig_val >= tb;
	assign prod = PROD_W'(e_acc) * PROD_W'(tb) + PROD_W'(word.dig_val);
	assign lim  = e_neg ? PROD_W'(VAL_MIN) : PROD_W'(VAL_MAX);
	assign ovf_hit = prod > lim;
	assign finish  = (act == ACT_DIGIT && bad) || act == ACT_END_X;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (go) begin
			case (act)
				ACT_NONE:   phase_d = e_phase;
				ACT_SIGN:   phase_d = PH_SIGN;
				ACT_ZERO:   phase_d = PH_ZERO;
				ACT_PREFIX: phase_d = PH_PREFIX;
				ACT_DIGIT:  phase_d = bad ? PH_DONE : PH_DIGITS;
				ACT_END_X:  phase_d = PH_DONE;
				default:    phase_d = e_phase;
			endcase
		end
	end

	// Next datapath state
	always_comb begin
		neg_d  = e_neg;
		base_d = e_base;
		acc_d  = e_acc;
		ovf_d  = e_ovf;
		anyd_d = e_anyd;
		case (act)
			ACT_SIGN: neg_d = word.is_minus;
			ACT_ZERO: begin
				anyd_d = 1'b1;
				acc_d  = '0;
			end
			ACT_PREFIX: base_d = BASE_HEX;
			ACT_DIGIT: begin
				base_d = tb;
				if (!bad) begin
					anyd_d = 1'b1;
					if (e_ovf || ovf_hit) begin
						ovf_d = 1'b1;
					end else begin
						acc_d = prod[VALUE_W-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	// Build the result word
	always_comb begin
		fin_off = word.offset;
		if (act == ACT_END_X && word.offset != '0) begin
			fin_off = word.offset - 1'b1;
		end
		res_push        = go && finish;
		res.range_error = e_ovf;
		res.digits_seen = e_anyd;
		res.end_offset  = e_anyd ? END_OFS_W'(fin_off) : '0;
		if (e_ovf) begin
			res.value = e_neg ? VAL_MIN : VAL_MAX;
		end else begin
			res.value = e_neg ? (VALUE_W'(0) - e_acc) : e_acc;
		end
	end

	// Update parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			neg_q   <= 1'b0;
			base_q  <= '0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			anyd_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (go) begin
				neg_q  <= neg_d;
				base_q <= base_d;
				acc_q  <= acc_d;
				ovf_q  <= ovf_d;
				anyd_q <= anyd_d;
			end
		end
	end

endmodule
`default_nettype wire

/* design/ttsi_result_q.sv */
`default_nettype none
module ttsi_result_q import ttsi_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr,
	input  wire result_t wr_res,
	output logic         full,
	input  wire logic    rd,
	output logic         empty,
	output result_t      rd_res
);

	result_t              mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_CNT_W-1:0] cnt_q;

	assign full   = (cnt_q == RES_CNT_W'(RES_DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_res = mem_q[rd_ptr_q];

	// Store the finished result
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_res;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/text_to_signed_integer_parser.sv */
// Path: the terminating character is written into the word queue, the back end
//   builds the result from the queue head, and the result is held in the result
//   queue until popped.
// Throughput: one character per cycle while full is low, with a combinational MAC
//   and range compare in the back end; full rises only when the result side stalls.
// Reset (arst_n low): queues empty, parser idle until a start flag, radix 0.
`default_nettype none
module text_to_signed_integer_parser import ttsi_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [CHAR_W-1:0]         char_code,
	input  wire logic                      string_start,
	input  wire logic                      push,
	output logic                           full,
	output logic signed [VALUE_W-1:0]      parsed_value,
	output logic                           range_error,
	output logic                           digits_seen,
	output logic [END_OFS_W-1:0]           end_offset,
	output logic                           empty,
	input  wire logic                      pop,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [BASE_W-1:0]         cfg_data
);

	class_word_t fe_word;
	class_word_t be_word;
	logic        fe_wr;
	logic        mid_empty;
	logic        mid_pop;
	logic        res_full;
	logic        res_push;
	result_t     be_res;
	result_t     head_res;

	ttsi_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_code    (char_code),
		.string_start (string_start),
		.push         (push),
		.q_full       (full),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.cfg_ready    (cfg_ready),
		.q_wr         (fe_wr),
		.q_word       (fe_word)
	);

	ttsi_word_q u_word_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fe_wr),
		.wr_word (fe_word),
		.full    (full),
		.rd      (mid_pop),
		.empty   (mid_empty),
		.rd_word (be_word)
	);

	ttsi_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.word     (be_word),
		.q_empty  (mid_empty),
		.q_pop    (mid_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (be_res)
	);

	ttsi_result_q u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wr_res (be_res),
		.full   (res_full),
		.rd     (pop && !empty),
		.empty  (empty),
		.rd_res (head_res)
	);

	// Drive the result ports from the oldest word
	assign parsed_value = head_res.value;
	assign range_error  = head_res.range_error;
	assign digits_seen  = head_res.digits_seen;
	assign end_offset   = head_res.end_offset;

endmodule
`default_nettype wire

/* test/tb_text_to_signed_integer_parser.sv */
module tb_text_to_signed_integer_parser;
	import ttsi_pkg::*;

	localparam int  CLK_PERIOD   = 12;
	localparam int  DRAIN_CYCLES = 12;
	localparam int  PHASE_ITEMS  = 100;
	localparam int  PICK_RADIX   = -1;
	localparam time RUN_LIMIT    = 64'd24_000_000;
	localparam logic [6:0]        NOT_DIGIT = 7'd99;
	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TOP    = 8'hff;

	// Tracks the parse of the character stream and keeps the results still owed
	class number_parse_board;
		phase_t                 phase;
		logic [BASE_W-1:0]      radix_reg;
		logic [BASE_W-1:0]      radix;
		logic                   minus;
		logic                   overflow_hit;
		logic                   got_digit;
		logic [VALUE_W-1:0]     acc;
		logic [OFFSET_BITS-1:0] position;
		result_t                due_results[$];
		int                     errors;
		int                     results_seen;
		int                     strings_seen;

		function new();
			radix_reg = BASE_AUTO;
			radix = BASE_AUTO;
			phase = PH_DONE;
			minus = 1'b0;
			overflow_hit = 1'b0;
			got_digit = 1'b0;
			acc = '0;
			position = '0;
			errors = 0;
			results_seen = 0;
			strings_seen = 0;
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10)
				$display("MISMATCH at %0t: %s", $time, what);
		endfunction

		function logic [6:0] digit_of(logic [CHAR_W-1:0] c);
			if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
			if (c >= CH_UA && c <= CH_UZ) return c - CH_UPPER_OFS;
			if (c >= CH_LA && c <= CH_LZ) return c - CH_LOWER_OFS;
			return NOT_DIGIT;
		endfunction

		// Close the number and queue the result it owes
		function void emit(logic [OFFSET_BITS-1:0] at);
			result_t r;
			if (overflow_hit)
				r.value = minus ? VAL_MIN : VAL_MAX;
			else
				r.value = minus ? -acc : acc;
			r.range_error = overflow_hit;
			r.digits_seen = got_digit;
			r.end_offset = got_digit ? at : '0;
			due_results.push_back(r);
			phase = PH_DONE;
		endfunction

		// Accumulate one digit, saturate past the int64 range, or end the number
		function void take_digit(logic [CHAR_W-1:0] c);
			logic [VALUE_W-1:0] lim;
			logic [VALUE_W-1:0] cutoff;
			logic [VALUE_W-1:0] cutlim;
			logic [6:0]         d;
			d = digit_of(c);
			if (radix < BASE_MIN || radix > BASE_MAX || d >= radix) begin
				emit(position);
				return;
			end
			lim = minus ? VAL_MIN : VAL_MAX;
			cutoff = lim / radix;
			cutlim = lim % radix;
			if (overflow_hit || acc > cutoff || (acc == cutoff && d > cutlim))
				overflow_hit = 1'b1;
			else
				acc = acc * radix + d;
			got_digit = 1'b1;
			phase = PH_DIGITS;
		endfunction

		function void take_first(logic [CHAR_W-1:0] c);
			if ((radix == BASE_AUTO || radix == BASE_HEX) && c == CH_ZERO) begin
				got_digit = 1'b1;
				acc = '0;
				phase = PH_ZERO;
			end else begin
				if (radix == BASE_AUTO)
					radix = BASE_DEC;
				take_digit(c);
			end
		endfunction

		function void note_char(logic [CHAR_W-1:0] c, logic first);
			if (first) begin
				phase = PH_SPACE;
				minus = 1'b0;
				radix = radix_reg;
				acc = '0;
				overflow_hit = 1'b0;
				got_digit = 1'b0;
				position = '0;
				strings_seen++;
			end
			if (phase == PH_DONE)
				return;
			case (phase)
				PH_SPACE: begin
					if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
						if (c == CH_MINUS || c == CH_PLUS) begin
							minus = (c == CH_MINUS);
							phase = PH_SIGN;
						end else begin
							take_first(c);
						end
					end
				end
				PH_SIGN: take_first(c);
				PH_ZERO: begin
					if (c == CH_LX || c == CH_UX) begin
						radix = BASE_HEX;
						phase = PH_PREFIX;
					end else begin
						if (radix == BASE_AUTO)
							radix = BASE_OCT;
						take_digit(c);
					end
				end
				// only the zero counts when no hex digit follows the prefix
				PH_PREFIX: begin
					if (digit_of(c) < 16)
						take_digit(c);
					else
						emit(position > 0 ? position - 1'b1 : '0);
				end
				default: take_digit(c);
			endcase
			if (position < POS_MAX)
				position++;
		endfunction

		function void check_result(logic signed [VALUE_W-1:0] v, logic re, logic ds,
				logic [END_OFS_W-1:0] eo);
			result_t want;
			if (due_results.size() == 0) begin
				flag($sformatf("result with nothing due: value %0d range %0b digits %0b ofs %0d",
					v, re, ds, eo));
				return;
			end
			want = due_results.pop_front();
			results_seen++;
			if (v !== want.value)
				flag($sformatf("parsed_value expected %0d, got %0d", want.value, v));
			if (re !== want.range_error)
				flag($sformatf("range_error expected %0b, got %0b", want.range_error, re));
			if (ds !== want.digits_seen)
				flag($sformatf("digits_seen expected %0b, got %0b", want.digits_seen, ds));
			if (eo !== want.end_offset)
				flag($sformatf("end_offset expected %0d, got %0d", want.end_offset, eo));
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic [CHAR_W-1:0]         char_code;
	logic                      string_start;
	logic                      push;
	logic                      full;
	logic signed [VALUE_W-1:0] parsed_value;
	logic                      range_error;
	logic                      digits_seen;
	logic [END_OFS_W-1:0]      end_offset;
	logic                      empty;
	logic                      pop;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [BASE_W-1:0]         cfg_data;

	number_parse_board board = new();
	logic [CHAR_W-1:0] word_chars[$];
	bit  idle_on = 1'b1;
	int  long_hold = 0;
	int  items_sent = 0;
	int  full_cycles = 0;
	int  radix_writes = 0;

	text_to_signed_integer_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_code    (char_code),
		.string_start (string_start),
		.push         (push),
		.full         (full),
		.parsed_value (parsed_value),
		.range_error  (range_error),
		.digits_seen  (digits_seen),
		.end_offset   (end_offset),
		.empty        (empty),
		.pop          (pop),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Offer one character, with an occasional idle burst ahead of it
	task automatic send_char(input logic [CHAR_W-1:0] c, input logic first);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		push <= 1'b1;
		char_code <= c;
		string_start <= first;
		@(posedge clk);
		while (full) begin
			full_cycles++;
			@(posedge clk);
		end
		board.note_char(c, first);
		items_sent++;
	endtask

	task automatic send_text();
		foreach (word_chars[i])
			send_char(word_chars[i], i == 0);
	endtask

	function automatic void add_str(string s);
		word_chars.delete();
		for (int i = 0; i < s.len(); i++)
			word_chars.push_back(s[i]);
	endfunction

	// Wait out every owed result and whatever is still in flight
	task automatic wait_idle();
		push <= 1'b0;
		while (board.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_radix(input logic [BASE_W-1:0] b);
		wait_idle();
		cfg_data <= b;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.radix_reg = b;
		radix_writes++;
	endtask

	function automatic logic [CHAR_W-1:0] digit_char(int d);
		if (d < 10)
			return CHAR_W'(CH_ZERO + d);
		return CHAR_W'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10);
	endfunction

	// Build one string: blanks, sign, prefix, digits or a value at the int64 edge,
	// then a terminator, or none so that the next start abandons the parse
	function automatic void build_random_text(logic [BASE_W-1:0] base);
		int             eff;
		int             n;
		int             kind;
		bit             neg;
		logic [VALUE_W:0] mag;
		string          stops;
		stops = " ,;.\n)";
		word_chars.delete();
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				word_chars.push_back($urandom_range(0, 5) == 5 ? CH_SPACE :
					CHAR_W'(CH_TAB + $urandom_range(0, 4)));
		neg = 1'b0;
		case ($urandom_range(0, 3))
			0: begin
				word_chars.push_back(CH_MINUS);
				neg = 1'b1;
			end
			1: word_chars.push_back(CH_PLUS);
			default: ;
		endcase
		eff = (base == BASE_AUTO) ? BASE_DEC : base;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(1, 4)) word_chars.push_back(CHAR_W'($urandom_range(0, 255)));
		end else begin
			if ((base == BASE_AUTO || base == BASE_HEX) && $urandom_range(0, 2) == 0) begin
				word_chars.push_back(CH_ZERO);
				word_chars.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
				eff = BASE_HEX;
			end else if (base == BASE_AUTO && $urandom_range(0, 3) == 0) begin
				word_chars.push_back(CH_ZERO);
				eff = BASE_OCT;
			end
			// with a radix the block rejects, any digit text will do
			if (eff < BASE_MIN || eff > BASE_MAX)
				eff = BASE_DEC;
			if (kind == 1) begin
				mag = {1'b0, VAL_MAX} + (VALUE_W + 1)'(neg) +
					(VALUE_W + 1)'($urandom_range(0, 4)) - (VALUE_W + 1)'(2);
				n = word_chars.size();
				do begin
					word_chars.insert(n, digit_char(int'(mag % eff)));
					mag = mag / eff;
				end while (mag != 0);
			end else begin
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
				repeat (n) word_chars.push_back(digit_char($urandom_range(0, eff - 1)));
			end
		end
		case ($urandom_range(0, 9))
			0: ;
			1: word_chars.push_back(CH_NUL);
			2: word_chars.push_back(CHAR_W'($urandom_range(128, 255)));
			3: word_chars.push_back(CHAR_W'($urandom_range(0, 255)));
			default: word_chars.push_back(stops[$urandom_range(0, 5)]);
		endcase
	endfunction

	// Result side: pop with random holds, plus one long hold on request
	initial begin
		int hold_left;
		hold_left = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				board.check_result(parsed_value, range_error, digits_seen, end_offset);
			if (long_hold > 0) begin
				hold_left = long_hold;
				long_hold = 0;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				pop <= 1'b0;
				hold_left = $urandom_range(0, 4);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		#RUN_LIMIT;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int radix_plan[13];
		int base;
		int phase_end;
		radix_plan = '{0, 10, 16, 8, 2, 36, 1, 63, PICK_RADIX, 37, 0, 16, 10};
		arst_n = 1'b0;
		push = 1'b0;
		char_code = '0;
		string_start = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings with radix detection
		write_radix(BASE_AUTO);
		add_str("\t-0x1f;");
		send_text();
		add_str("0777");
		word_chars.push_back(CH_NUL);
		send_text();
		add_str("0xg");
		send_text();
		send_char(CH_UZ, 1'b0);
		add_str("12");
		send_text();
		add_str("+ 5");
		send_text();
		word_chars.delete();
		word_chars.push_back(CH_TOP);
		send_text();

		// Random strings across radix settings
		foreach (radix_plan[p]) begin
			base = (radix_plan[p] == PICK_RADIX) ? $urandom_range(2, 35) : radix_plan[p];
			write_radix(BASE_W'(base));
			idle_on = (p != $size(radix_plan) - 1);
			if (p == 0)
				long_hold = 300;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				build_random_text(BASE_W'(base));
				send_text();
				if ($urandom_range(0, 7) == 0)
					send_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
			end
		end

		wait_idle();
		$display("Covered %0d characters in %0d strings over %0d radix writes.",
			items_sent, board.strings_seen, radix_writes);
		$display("Checked %0d results with %0d mismatches; input stalled on full for %0d cycles.",
			board.results_seen, board.errors, full_cycles);
		if (board.errors == 0 && board.due_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
design/ttsi_pkg.sv
design/ttsi_front.sv
design/ttsi_word_q.sv
design/ttsi_back.sv
design/ttsi_result_q.sv
design/text_to_signed_integer_parser.sv
test/tb_text_to_signed_integer_parser.sv
